// ----- rtl/player_command_framer_macros.svh -----
// Assertion macros shared by the framer RTL.
`ifndef PLAYER_COMMAND_FRAMER_MACROS_SVH
`define PLAYER_COMMAND_FRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcf assertion failed");

// Next-cycle implication, checked outside reset.
`define PCF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcf assertion failed");

`endif

// ----- rtl/pcf_pkg.sv -----
// Types, constants and helper functions for the command framer.
package pcf_pkg;

    localparam int unsigned FRAME_LEN = 10;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned VOL_W     = 5;
    localparam int unsigned QDEPTH    = 2;
    localparam int unsigned QPTR_W    = 1;
    localparam int unsigned QCNT_W    = 2;

    localparam logic [VOL_W-1:0] VOL_MAX   = 5'd30;
    localparam logic [VOL_W-1:0] VOL_RESET = 5'd10;

    localparam logic [7:0] FRAME_START   = 8'h7E;
    localparam logic [7:0] FRAME_VERSION = 8'hFF;
    localparam logic [7:0] FRAME_LENGTH  = 8'h06;
    localparam logic [7:0] FRAME_FEEDBK  = 8'h00;
    localparam logic [7:0] FRAME_END     = 8'hEF;

    localparam logic [7:0] CMD_NEXT   = 8'h01;
    localparam logic [7:0] CMD_PREV   = 8'h02;
    localparam logic [7:0] CMD_PLAY   = 8'h0D;
    localparam logic [7:0] CMD_PAUSE  = 8'h0E;
    localparam logic [7:0] CMD_RESET  = 8'h0C;
    localparam logic [7:0] CMD_VOLUME = 8'h06;

    // Byte positions within a frame
    localparam logic [IDX_W-1:0] BYTE_START   = 4'd0;
    localparam logic [IDX_W-1:0] BYTE_VERSION = 4'd1;
    localparam logic [IDX_W-1:0] BYTE_LENGTH  = 4'd2;
    localparam logic [IDX_W-1:0] BYTE_CODE    = 4'd3;
    localparam logic [IDX_W-1:0] BYTE_FEEDBK  = 4'd4;
    localparam logic [IDX_W-1:0] BYTE_PARAM_H = 4'd5;
    localparam logic [IDX_W-1:0] BYTE_PARAM_L = 4'd6;
    localparam logic [IDX_W-1:0] BYTE_CHECK_H = 4'd7;
    localparam logic [IDX_W-1:0] BYTE_CHECK_L = 4'd8;
    localparam logic [IDX_W-1:0] BYTE_END     = 4'd9;

    typedef enum logic [2:0] {
        REQ_NEXT     = 3'd0,
        REQ_PREV     = 3'd1,
        REQ_PLAY     = 3'd2,
        REQ_PAUSE    = 3'd3,
        REQ_RESET    = 3'd4,
        REQ_VOL_UP   = 3'd5,
        REQ_VOL_DOWN = 3'd6,
        REQ_VOL_SET  = 3'd7
    } t_req;

    // One classified command, as held in the queue
    typedef struct packed {
        logic [7:0]       code;
        logic [VOL_W-1:0] param;
        logic [15:0]      check;
    } t_cmd;

    // Map a request kind to its command code
    function automatic logic [7:0] req_code(input t_req req);
        logic [7:0] code;
        unique case (req)
            REQ_NEXT:  code = CMD_NEXT;
            REQ_PREV:  code = CMD_PREV;
            REQ_PLAY:  code = CMD_PLAY;
            REQ_PAUSE: code = CMD_PAUSE;
            REQ_RESET: code = CMD_RESET;
            default:   code = CMD_VOLUME;
        endcase
        return code;
    endfunction

    // Select one frame byte of a command
    function automatic logic [7:0] frame_sel(input t_cmd cmd, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            BYTE_START:   b = FRAME_START;
            BYTE_VERSION: b = FRAME_VERSION;
            BYTE_LENGTH:  b = FRAME_LENGTH;
            BYTE_CODE:    b = cmd.code;
            BYTE_FEEDBK:  b = FRAME_FEEDBK;
            BYTE_PARAM_H: b = 8'h00;
            BYTE_PARAM_L: b = {{(8-VOL_W){1'b0}}, cmd.param};
            BYTE_CHECK_H: b = cmd.check[15:8];
            BYTE_CHECK_L: b = cmd.check[7:0];
            BYTE_END:     b = FRAME_END;
            default:      b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/pcf_front.sv -----
// Front end: accepts requests, tracks the volume level and builds queue entries.
module pcf_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [2:0]                 i_req_type,
    input  logic [7:0]                 i_set_level,
    input  logic                       i_q_ready,
    output logic                       o_q_push,
    output pcf_pkg::t_cmd              o_q_data
);
    import pcf_pkg::*;

    logic [VOL_W-1:0] r_volume;
    logic [VOL_W-1:0] n_volume;
    logic [VOL_W-1:0] w_param;
    logic [8:0]       w_sum;
    t_req             w_req;

    assign w_req      = t_req'(i_req_type);
    assign o_in_ready = i_q_ready;
    assign o_q_push   = i_in_valid && i_q_ready;

    // Step, hold or load the volume level by request kind
    always_comb begin
        n_volume = r_volume;
        w_param  = '0;
        case (w_req)
            REQ_VOL_UP: begin
                if (r_volume < VOL_MAX) n_volume = r_volume + 5'd1;
                w_param = n_volume;
            end
            REQ_VOL_DOWN: begin
                if (r_volume != '0) n_volume = r_volume - 5'd1;
                w_param = n_volume;
            end
            REQ_VOL_SET: begin
                if (i_set_level > {3'b000, VOL_MAX}) n_volume = VOL_MAX;
                else n_volume = i_set_level[VOL_W-1:0];
                w_param = n_volume;
            end
            default: begin
                n_volume = r_volume;
            end
        endcase
    end

    // Build the queue entry with its checksum
    always_comb begin
        w_sum = {1'b0, FRAME_VERSION} + {1'b0, FRAME_LENGTH} + {1'b0, req_code(w_req)}
              + {4'b0000, w_param};
        o_q_data.code  = req_code(w_req);
        o_q_data.param = w_param;
        o_q_data.check = 16'h0000 - {7'b0000000, w_sum};
    end

    // Update volume on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= VOL_RESET;
        end else if (o_q_push) begin
            r_volume <= n_volume;
        end
    end

endmodule

// ----- rtl/pcf_queue.sv -----
// Two-entry command queue between the front and back ends.
module pcf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pcf_pkg::t_cmd i_data,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output pcf_pkg::t_cmd o_data
);
    import pcf_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (w_push && !w_pop) r_count <= r_count + 1'b1;
            else if (w_pop && !w_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

// ----- rtl/pcf_back.sv -----
// Back end: serializes the queue head into ten frame bytes.
module pcf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  pcf_pkg::t_cmd i_q_data,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_frame_byte,
    output logic          o_last_byte
);
    import pcf_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             w_free;
    logic             w_emit;
    logic             w_is_last;

    assign w_free      = !r_valid || i_out_ready;
    assign w_emit      = w_free && i_q_valid;
    assign w_is_last   = (r_idx == BYTE_END);
    assign o_q_pop     = w_emit && w_is_last;
    assign o_out_valid = r_valid;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last;

    // Advance the byte index and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= BYTE_START;
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= i_q_valid;
            if (w_emit) begin
                r_idx <= w_is_last ? BYTE_START : r_idx + 4'd1;
            end
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_byte <= frame_sel(i_q_data, r_idx);
            r_last <= w_is_last;
        end
    end

endmodule

// ----- rtl/player_command_framer.sv -----
// Top level of the serial player command framer.
//
//  channel   dir  handshake                   payload
//  request   in   i_in_valid / o_in_ready     i_req_type, i_set_level
//  frame     out  o_out_valid / i_out_ready   o_frame_byte, o_last_byte
//
// Each request yields ten frame bytes, one per cycle at most: the byte
// serializer in the back end sets the rate. A request is taken while the
// two-entry queue has room, so the front accepts during serialization; a
// request is registered in the queue, then its first byte in the output register.
// Reset (synchronous, active low) empties the queue and sets volume to 10.
// A stalled output holds its byte; the back end waits and the queue fills.
module player_command_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_set_level,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_frame_byte,
    output logic       o_last_byte
);
    import pcf_pkg::*;
`include "player_command_framer_macros.svh"

    logic w_q_ready;
    logic w_q_push;
    logic w_q_valid;
    logic w_q_pop;
    t_cmd w_push_data;
    t_cmd w_head_data;

    // Classify requests
    pcf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_set_level (i_set_level),
        .i_q_ready   (w_q_ready),
        .o_q_push    (w_q_push),
        .o_q_data    (w_push_data)
    );

    // Buffer commands
    pcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_push_data),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_head_data)
    );

    // Serialize frames
    pcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_data     (w_head_data),
        .o_q_pop      (w_q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

    // Closing byte of each frame is the end marker
    `PCF_ASSERT_IMP(a_last_is_end, i_clk, i_rst_n, o_out_valid && o_last_byte, o_frame_byte == FRAME_END)
    // A blocked front (queue full) implies a pending command at the queue head
    `PCF_ASSERT_IMP(a_blocked_has_head, i_clk, i_rst_n, !o_in_ready, w_q_valid)
    // The byte after a closing byte opens a new frame
    `PCF_ASSERT_NXT(a_next_frame_start, i_clk, i_rst_n, o_out_valid && i_out_ready && o_last_byte, !o_out_valid || (o_frame_byte == FRAME_START && !o_last_byte))

endmodule
